[rtl/aspf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspf_pkg
// Shared types and constants for the alternating servo position framer.
// ----------------------------------------------------------------------------
package aspf_pkg;

    localparam int ANGLE_W = 16;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 12;
    localparam int MAG_W   = 14;
    localparam int NUM_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd11520;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT_N = -16'sd11520;

    // pos offset = a * 1024 / 11520 = a * 4 / 45
    localparam int SPAN_MUL  = 4;
    localparam int ANGLE_DIV = 45;
    localparam logic [NUM_W-1:0] CEIL_BIAS = NUM_W'(ANGLE_DIV - 1);

    // floor(n / 45) = (n * RECIP) >> RECIP_SHIFT, exact for n < 2^16
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / ANGLE_DIV + 1);
    localparam int PROD_W = NUM_W + RECIP_W;

    localparam logic [POS_W-1:0] POS_MID = 12'd2048;

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] WRITE_LEN  = 8'h05;
    localparam logic [BYTE_W-1:0] INST_WRITE = 8'h03;
    localparam logic [BYTE_W-1:0] REG_GOAL   = 8'h2A;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_Y    = 2'd2;

    localparam logic [BYTE_W-1:0] RESET_ID_X = 8'd1;
    localparam logic [BYTE_W-1:0] RESET_ID_Y = 8'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] id;
        logic [POS_W-1:0]  pos;
        logic              is_y;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        SLOT_IDLE,
        SLOT_HDR0,
        SLOT_HDR1,
        SLOT_ID,
        SLOT_LEN,
        SLOT_INST,
        SLOT_REG,
        SLOT_LO,
        SLOT_HI,
        SLOT_CHK
    } slot_t;

endpackage

[rtl/aspf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspf_if
// Tick, packet byte and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface aspf_tick_if;
    import aspf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;

    modport source (output valid, output angle_x, output angle_y, input ready);
    modport sink (input valid, input angle_x, input angle_y, output ready);
endinterface

interface aspf_byte_if;
    import aspf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
    logic              axis_is_y;

    modport source (output valid, output out_byte, output last_byte, output axis_is_y,
                    input ready);
    modport sink (input valid, input out_byte, input last_byte, input axis_is_y,
                  output ready);
endinterface

interface aspf_cfg_if;
    import aspf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/aspf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspf_front
// Config registers, axis alternation, clamp and position mapping.
// ----------------------------------------------------------------------------
module aspf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    aspf_tick_if.sink              tick,
    aspf_cfg_if.sink               cfg,
    input  aspf_pkg::queue_status_t q_status,
    output logic                   push,
    output aspf_pkg::queue_entry_t push_entry
);
    import aspf_pkg::*;

    logic              enabled_reg, enabled_next;
    logic [BYTE_W-1:0] id_x_reg, id_x_next;
    logic [BYTE_W-1:0] id_y_reg, id_y_next;
    logic              next_x_reg, next_x_next;

    logic              stg_valid_reg, stg_valid_next;
    logic [NUM_W-1:0]  stg_num_reg, stg_num_next;
    logic              stg_neg_reg, stg_neg_next;
    logic [BYTE_W-1:0] stg_id_reg, stg_id_next;
    logic              stg_y_reg, stg_y_next;

    logic                      accept;
    logic                      take;
    logic                      stg_adv;
    logic signed [ANGLE_W-1:0] sel;
    logic signed [ANGLE_W-1:0] sel_abs;
    logic [MAG_W-1:0]          mag;
    logic [PROD_W-1:0]         prod;
    logic [POS_W-1:0]          quo;

    assign cfg.ready  = 1'b1;
    assign stg_adv    = stg_valid_reg && !q_status.full;
    assign tick.ready = !stg_valid_reg || !q_status.full;
    assign accept     = tick.valid && tick.ready;
    assign take       = accept && enabled_reg;

    always_comb
    begin
        enabled_next = enabled_reg;
        id_x_next    = id_x_reg;
        id_y_next    = id_y_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ENABLED: enabled_next = cfg.data[0];
                CFG_ID_X:    id_x_next    = cfg.data;
                CFG_ID_Y:    id_y_next    = cfg.data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        sel     = next_x_reg ? tick.angle_x : tick.angle_y;
        sel_abs = -sel;
        if (sel > ANGLE_LIMIT || sel < ANGLE_LIMIT_N)
        begin
            mag = MAG_W'(ANGLE_LIMIT);
        end
        else if (sel[ANGLE_W-1])
        begin
            mag = sel_abs[MAG_W-1:0];
        end
        else
        begin
            mag = sel[MAG_W-1:0];
        end
        // negative side rounds the quotient up
        stg_num_next = NUM_W'(mag) * NUM_W'(SPAN_MUL)
                     + (sel[ANGLE_W-1] ? CEIL_BIAS : '0);
        stg_neg_next = sel[ANGLE_W-1];
        stg_id_next  = next_x_reg ? id_x_reg : id_y_reg;
        stg_y_next   = !next_x_reg;
        next_x_next  = take ? !next_x_reg : next_x_reg;
        if (take)
        begin
            stg_valid_next = 1'b1;
        end
        else if (stg_adv)
        begin
            stg_valid_next = 1'b0;
        end
        else
        begin
            stg_valid_next = stg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            id_x_reg      <= RESET_ID_X;
            id_y_reg      <= RESET_ID_Y;
            next_x_reg    <= 1'b1;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            id_x_reg      <= id_x_next;
            id_y_reg      <= id_y_next;
            next_x_reg    <= next_x_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_num_reg <= stg_num_next;
            stg_neg_reg <= stg_neg_next;
            stg_id_reg  <= stg_id_next;
            stg_y_reg   <= stg_y_next;
        end
    end

    always_comb
    begin
        prod = PROD_W'(stg_num_reg) * PROD_W'(RECIP);
        quo  = POS_W'(prod[PROD_W-1:RECIP_SHIFT]);
        push = stg_adv;
        push_entry.id   = stg_id_reg;
        push_entry.pos  = stg_neg_reg ? (POS_MID - quo) : (POS_MID + quo);
        push_entry.is_y = stg_y_reg;
    end

endmodule

[rtl/aspf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspf_queue
// Small FIFO of mapped packet requests between front and back.
// ----------------------------------------------------------------------------
module aspf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  aspf_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output aspf_pkg::queue_entry_t  head,
    output aspf_pkg::queue_status_t status
);
    import aspf_pkg::*;

    queue_entry_t      slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/aspf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspf_back
// Packet sequencer: checksum, one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module aspf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  aspf_pkg::queue_entry_t  head,
    input  aspf_pkg::queue_status_t q_status,
    output logic                    pop,
    aspf_byte_if.source             pkt
);
    import aspf_pkg::*;

    slot_t             slot_reg, slot_next;
    logic [BYTE_W-1:0] cur_id_reg;
    logic [POS_W-1:0]  cur_pos_reg;
    logic              cur_y_reg;
    logic [BYTE_W-1:0] cur_chk_reg, chk_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_y_reg;

    logic              load_out;
    logic              emit;
    logic [BYTE_W-1:0] byte_sel;
    logic              last_sel;
    logic [BYTE_W-1:0] sum;

    assign load_out = !out_valid_reg || pkt.ready;

    always_comb
    begin
        pop = !q_status.empty
            && ((slot_reg == SLOT_IDLE) || (slot_reg == SLOT_CHK && load_out));
        slot_next = slot_reg;
        case (slot_reg)
            SLOT_IDLE: slot_next = pop ? SLOT_HDR0 : SLOT_IDLE;
            SLOT_HDR0: slot_next = load_out ? SLOT_HDR1 : SLOT_HDR0;
            SLOT_HDR1: slot_next = load_out ? SLOT_ID : SLOT_HDR1;
            SLOT_ID:   slot_next = load_out ? SLOT_LEN : SLOT_ID;
            SLOT_LEN:  slot_next = load_out ? SLOT_INST : SLOT_LEN;
            SLOT_INST: slot_next = load_out ? SLOT_REG : SLOT_INST;
            SLOT_REG:  slot_next = load_out ? SLOT_LO : SLOT_REG;
            SLOT_LO:   slot_next = load_out ? SLOT_HI : SLOT_LO;
            SLOT_HI:   slot_next = load_out ? SLOT_CHK : SLOT_HI;
            SLOT_CHK:
            begin
                if (load_out)
                begin
                    slot_next = pop ? SLOT_HDR0 : SLOT_IDLE;
                end
            end
            default:   slot_next = SLOT_IDLE;
        endcase
    end

    always_comb
    begin
        last_sel = 1'b0;
        case (slot_reg)
            SLOT_HDR0: byte_sel = HDR_BYTE;
            SLOT_HDR1: byte_sel = HDR_BYTE;
            SLOT_ID:   byte_sel = cur_id_reg;
            SLOT_LEN:  byte_sel = WRITE_LEN;
            SLOT_INST: byte_sel = INST_WRITE;
            SLOT_REG:  byte_sel = REG_GOAL;
            SLOT_LO:   byte_sel = cur_pos_reg[BYTE_W-1:0];
            SLOT_HI:   byte_sel = BYTE_W'(cur_pos_reg[POS_W-1:BYTE_W]);
            SLOT_CHK:
            begin
                byte_sel = cur_chk_reg;
                last_sel = 1'b1;
            end
            default:   byte_sel = '0;
        endcase
        emit           = load_out && (slot_reg != SLOT_IDLE);
        out_valid_next = load_out ? emit : out_valid_reg;
    end

    always_comb
    begin
        sum = head.id + WRITE_LEN + INST_WRITE + REG_GOAL
            + head.pos[BYTE_W-1:0] + BYTE_W'(head.pos[POS_W-1:BYTE_W]);
        chk_next = ~sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_id_reg  <= head.id;
            cur_pos_reg <= head.pos;
            cur_y_reg   <= head.is_y;
            cur_chk_reg <= chk_next;
        end
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= last_sel;
            out_y_reg    <= cur_y_reg;
        end
    end

    assign pkt.valid     = out_valid_reg;
    assign pkt.out_byte  = out_byte_reg;
    assign pkt.last_byte = out_last_reg;
    assign pkt.axis_is_y = out_y_reg;

endmodule

[rtl/alternating_servo_position_framer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_servo_position_framer_core
// Two-axis goal-position write packet framer, one axis served per tick.
// ----------------------------------------------------------------------------
//  channel | dir | request                          | payload
//  tick    | in  | one control tick                 | angle_x, angle_y (Q8.8 deg)
//  pkt     | out | one packet byte                  | out_byte, last_byte, axis_is_y
//  cfg     | in  | one register write, always ready | index, data
//
//  A tick is taken when staging or queue has room; a disabled tick yields no
//  bytes. Each packet is 9 bytes at one byte per cycle unless the sink stalls,
//  set by the byte sequencer; requests pass staging register, queue, sequencer.
//  A two-entry request queue lets ticks enter while a packet is still sent.
//  Reset: disabled, ids 1 and 2, X served first; output holds under stall.
// ----------------------------------------------------------------------------
module alternating_servo_position_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    aspf_tick_if.sink   tick,
    aspf_byte_if.source pkt,
    aspf_cfg_if.sink    cfg
);
    import aspf_pkg::*;

    queue_status_t q_status;
    queue_entry_t  push_entry;
    queue_entry_t  head;
    logic          push;
    logic          pop;

    aspf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg        (cfg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    aspf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    aspf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .pkt      (pkt)
    );

endmodule

[rtl/aspf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspf_checker
// Port-level checks on packet framing, bound to the framer top level.
// ----------------------------------------------------------------------------
module aspf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pkt_valid,
    input logic       pkt_ready,
    input logic [7:0] pkt_out_byte,
    input logic       pkt_last_byte,
    input logic       pkt_axis_is_y
);
    import aspf_pkg::*;

    localparam logic [3:0] LAST_POS = 4'd8;

    logic [3:0] pos_reg, pos_next;
    logic       axis_reg;
    logic       fire;

    assign fire     = pkt_valid && pkt_ready;
    assign pos_next = (pos_reg == LAST_POS) ? 4'd0 : pos_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 4'd0;
            axis_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg  <= pos_next;
            axis_reg <= pkt_axis_is_y;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_out_byte)
            && $stable(pkt_last_byte) && $stable(pkt_axis_is_y))
        else $error("stalled packet byte changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (pkt_last_byte == (pos_reg == LAST_POS)))
        else $error("last_byte not on ninth byte");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (pos_reg == 4'd0 || pos_reg == 4'd1) |-> pkt_out_byte == HDR_BYTE)
        else $error("packet header missing");

    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pos_reg != 4'd0 |-> pkt_axis_is_y == axis_reg)
        else $error("axis changed inside packet");

endmodule

bind alternating_servo_position_framer_core aspf_checker u_aspf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt_valid     (pkt.valid),
    .pkt_ready     (pkt.ready),
    .pkt_out_byte  (pkt.out_byte),
    .pkt_last_byte (pkt.last_byte),
    .pkt_axis_is_y (pkt.axis_is_y)
);

[bench/tb_alternating_servo_position_framer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alternating_servo_position_framer_core
// Self-checking bench for the two-axis goal-position packet framer.
// Tick requests come from a queue with random gaps. Every accepted tick is run
// through a local packet predictor that has its own copy of the registers and
// the axis toggle. Each packet byte the sink accepts is checked against the
// oldest predicted byte. Random stalls on the sink side. Register writes
// happen between phases, once the block is idle.
// ----------------------------------------------------------------------------
module tb_alternating_servo_position_framer_core;
    import aspf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int GAP_MAX       = 11;
    localparam int FRAME_BYTES   = 9;
    localparam int SWING_Q88     = 11520;
    localparam int CENTER_POS    = 2048;
    localparam int POS_STEPS     = 1024;
    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] GOAL_WR_LEN   = 8'h05;
    localparam logic [BYTE_W-1:0] OP_WRITE      = 8'h03;
    localparam logic [BYTE_W-1:0] GOAL_POS_ADDR = 8'h2A;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              is_y;
    } packet_byte_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] ax;
        logic signed [ANGLE_W-1:0] ay;
        int                        gap;
    } tick_req_t;

    logic clk = 1'b0;
    logic rst_n;

    aspf_tick_if tick_ch ();
    aspf_byte_if pkt_ch ();
    aspf_cfg_if  cfg_ch ();

    alternating_servo_position_framer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .pkt   (pkt_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // predictor state
    logic              pred_enabled;
    logic [BYTE_W-1:0] pred_id_x;
    logic [BYTE_W-1:0] pred_id_y;
    logic              pred_serve_x = 1'b1;

    packet_byte_t pending_bytes[$];
    tick_req_t    tick_pending[$];

    tick_req_t    tick_cur;
    bit           tick_loaded;
    int           tick_gap;
    bit           tick_calm;
    int           sink_hold;
    bit           sink_calm = 1'b0;
    packet_byte_t want;

    int cycle_count   = 0;
    int mismatches    = 0;
    int ticks_taken   = 0;
    int ticks_ignored = 0;
    int packets_seen  = 0;
    int bytes_seen    = 0;

    function automatic logic [POS_W-1:0] goal_position(logic signed [ANGLE_W-1:0] angle);
        int a;
        a = angle;
        if (a > SWING_Q88)
            a = SWING_Q88;
        if (a < -SWING_Q88)
            a = -SWING_Q88;
        if (a >= 0)
            return POS_W'(CENTER_POS + (a * POS_STEPS) / SWING_Q88);
        return POS_W'(CENTER_POS - ((-a * POS_STEPS) + SWING_Q88 - 1) / SWING_Q88);
    endfunction

    function automatic void frame_goal_packet(logic signed [ANGLE_W-1:0] ax,
                                              logic signed [ANGLE_W-1:0] ay);
        logic [BYTE_W-1:0] frame[FRAME_BYTES];
        logic [BYTE_W-1:0] chk_sum;
        logic [POS_W-1:0]  pos;
        logic              is_y;
        int                i;
        ticks_taken++;
        if (!pred_enabled) begin
            ticks_ignored++;
            return;
        end
        is_y = !pred_serve_x;
        pos = goal_position(is_y ? ay : ax);
        frame[0] = SYNC_BYTE;
        frame[1] = SYNC_BYTE;
        frame[2] = is_y ? pred_id_y : pred_id_x;
        frame[3] = GOAL_WR_LEN;
        frame[4] = OP_WRITE;
        frame[5] = GOAL_POS_ADDR;
        frame[6] = pos[7:0];
        frame[7] = BYTE_W'(pos >> 8);
        chk_sum = '0;
        for (i = 2; i < FRAME_BYTES - 1; i++)
            chk_sum += frame[i];
        frame[8] = ~chk_sum;
        for (i = 0; i < FRAME_BYTES; i++)
            pending_bytes.push_back('{frame[i], i == FRAME_BYTES - 1, is_y});
        pred_serve_x = !pred_serve_x;
    endfunction

    // tick request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            tick_ch.valid   <= 1'b0;
            tick_ch.angle_x <= '0;
            tick_ch.angle_y <= '0;
            tick_loaded = 1'b0;
            tick_gap = 0;
        end else begin
            if (tick_ch.valid && tick_ch.ready) begin
                frame_goal_packet(tick_ch.angle_x, tick_ch.angle_y);
                tick_loaded = 1'b0;
            end
            if (!tick_loaded && tick_pending.size() != 0) begin
                tick_cur = tick_pending.pop_front();
                tick_gap = tick_cur.gap;
                tick_loaded = 1'b1;
            end
            if (tick_loaded && tick_gap > 0) begin
                tick_gap--;
                tick_ch.valid <= 1'b0;
            end else if (tick_loaded) begin
                tick_ch.valid   <= 1'b1;
                tick_ch.angle_x <= tick_cur.ax;
                tick_ch.angle_y <= tick_cur.ay;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // packet byte monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            pkt_ch.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (pkt_ch.valid && pkt_ch.ready) begin
                bytes_seen++;
                if (pending_bytes.size() == 0) begin
                    $error("unexpected packet byte %h", pkt_ch.out_byte);
                    mismatches++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (want.last)
                        packets_seen++;
                    if (pkt_ch.out_byte !== want.value) begin
                        $error("out_byte: expected %h, got %h", want.value, pkt_ch.out_byte);
                        mismatches++;
                    end
                    if (pkt_ch.last_byte !== want.last) begin
                        $error("last_byte: expected %b, got %b", want.last, pkt_ch.last_byte);
                        mismatches++;
                    end
                    if (pkt_ch.axis_is_y !== want.is_y) begin
                        $error("axis_is_y: expected %b, got %b", want.is_y, pkt_ch.axis_is_y);
                        mismatches++;
                    end
                end
                sink_hold = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 31) == 0)
                    sink_calm = !sink_calm;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                pkt_ch.ready <= 1'b0;
            end else begin
                pkt_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_ENABLED: pred_enabled = value[0];
            CFG_ID_X:    pred_id_x = value;
            CFG_ID_Y:    pred_id_y = value;
            default:     ;
        endcase
    endtask

    task automatic queue_tick(input logic signed [ANGLE_W-1:0] ax,
                              input logic signed [ANGLE_W-1:0] ay);
        tick_pending.push_back('{ax, ay, tick_calm ? 0 : int'($urandom_range(0, GAP_MAX))});
        if ($urandom_range(0, 15) == 0)
            tick_calm = !tick_calm;
    endtask

    function automatic logic signed [ANGLE_W-1:0] draw_angle();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ANGLE_W'(int'($urandom_range(0, 2 * SWING_Q88)) - SWING_Q88);
            4, 5:       return ANGLE_W'(int'($urandom_range(0, 6)) - 3 +
                                        ($urandom_range(0, 1) ? SWING_Q88 : -SWING_Q88));
            6:          return ANGLE_W'(int'($urandom_range(0, 200)) - 100);
            default:    return ANGLE_W'($urandom);
        endcase
    endfunction

    // wait until every request is taken and every byte is back
    task automatic drain();
        while (tick_pending.size() != 0 || tick_loaded || pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    logic signed [ANGLE_W-1:0] edge_angles[15] = '{
        16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
        16'sd11520, -16'sd11520, 16'sd11521, -16'sd11521,
        16'sd44, 16'sd45, -16'sd45, -16'sd46, 16'sh5555, 16'shAAAA
    };

    initial begin
        int i;
        int ph;
        int n;
        rst_n = 1'b0;
        pred_enabled = 1'b0;
        pred_id_x = 8'd1;
        pred_id_y = 8'd2;
        tick_calm = 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // disabled after reset: no bytes, no toggle
        queue_tick(16'sh4000, -16'sh4000);
        queue_tick(16'sd0, 16'sd0);
        queue_tick(16'sd32767, -16'sd32768);
        drain();

        write_reg(CFG_ENABLED, 8'h01);
        for (i = 0; i < 15; i++)
            queue_tick(edge_angles[i], edge_angles[(i + 5) % 15]);
        drain();

        write_reg(CFG_ID_X, 8'd0);
        write_reg(CFG_ID_Y, 8'd255);
        queue_tick(16'sd11520, -16'sd11520);
        queue_tick(-16'sd11520, 16'sd11520);
        drain();

        // unmapped index must leave the ids alone
        write_reg(CFG_SPARE, 8'h5A);
        queue_tick(16'sd100, -16'sd100);
        queue_tick(-16'sd100, 16'sd100);
        drain();

        // odd number served so far; disabled ticks must not move the axis
        write_reg(CFG_ENABLED, 8'hFE);
        queue_tick(16'sd256, 16'sd512);
        queue_tick(16'sd768, 16'sd1024);
        drain();
        write_reg(CFG_ENABLED, 8'h81);
        queue_tick(16'sd2000, -16'sd2000);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            write_reg(CFG_ID_X, (ph == 1) ? 8'd253 : BYTE_W'($urandom));
            write_reg(CFG_ID_Y, (ph == 1) ? 8'd0 : BYTE_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_SPARE, BYTE_W'($urandom));
            write_reg(CFG_ENABLED, {7'($urandom), (ph == 3) ? 1'b0 : 1'b1});
            n = (ph == 3) ? 12 : 60;
            for (i = 0; i < n; i++)
                queue_tick(draw_angle(), draw_angle());
            drain();
        end

        $display("%0d ticks taken (%0d while disabled), %0d packets / %0d bytes checked",
                 ticks_taken, ticks_ignored, packets_seen, bytes_seen);
        $display("covered: angle saturation and rounding edges, id extremes, unmapped index");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/aspf_pkg.sv
rtl/aspf_if.sv
rtl/aspf_front.sv
rtl/aspf_queue.sv
rtl/aspf_back.sv
rtl/alternating_servo_position_framer_core.sv
rtl/aspf_checker.sv
bench/tb_alternating_servo_position_framer_core.sv
